FILE: sv/msync_pkg.sv
// ---------------------------------------------------------------------------
// msync_pkg
// Shared types and constants for the Manchester sync sampler.
// ---------------------------------------------------------------------------
package msync_pkg;

	// Timestamp arithmetic width; durations wrap modulo 2^TIME_WIDTH.
	localparam int TIME_WIDTH_DEFAULT = 32;

	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 32;
	localparam int TOL_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD  = CFG_IDX_W'(1);

	// Register reset values.
	localparam logic [TOL_W-1:0]    MATCH_TOLERANCE_RST = TOL_W'(75);
	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_RST  = PERIOD_W'(1000);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX          = '1;

	// Two equal samples in a row make one half-bit symbol.
	localparam logic [1:0] RUN_SYMBOL = 2'd2;
	localparam logic [1:0] RUN_FIRST  = 2'd1;

	// Phase codes as seen on the result channel.
	localparam logic [2:0] PHASE_CODE_WAIT  = 3'd0;
	localparam logic [2:0] PHASE_CODE_HIGH  = 3'd1;
	localparam logic [2:0] PHASE_CODE_LOW   = 3'd2;
	localparam logic [2:0] PHASE_CODE_SHIGH = 3'd3;
	localparam logic [2:0] PHASE_CODE_SLOW  = 3'd4;
	localparam logic [2:0] PHASE_CODE_ERR   = 3'd5;

	typedef enum logic [5:0] {
		PH_WAIT  = 6'b000001,
		PH_HIGH  = 6'b000010,
		PH_LOW   = 6'b000100,
		PH_SHIGH = 6'b001000,
		PH_SLOW  = 6'b010000,
		PH_ERR   = 6'b100000
	} phase_t;

	// Configuration values handed from the register file to the sampler core.
	typedef struct packed {
		logic [TOL_W-1:0]    match_tolerance;
		logic [PERIOD_W-1:0] default_period;
		logic                period_load;
	} msync_cfg_t;

	// One result item.
	typedef struct packed {
		logic                symbol_valid;
		logic                symbol_level;
		logic [PERIOD_W-1:0] sample_period_us;
		logic                locked;
		logic                sync_error;
		logic [2:0]          phase_code;
	} msync_result_t;

endpackage

FILE: sv/msync_sample_if.sv
// ---------------------------------------------------------------------------
// msync_sample_if
// Input channel: one line sample and its timestamp per item.
// ---------------------------------------------------------------------------
interface msync_sample_if;
	logic                       valid;
	logic                       ready;
	logic                       line_level;
	logic [msync_pkg::TIME_W-1:0] time_us;

	modport source (output valid, output line_level, output time_us, input ready);
	modport sink   (input valid, input line_level, input time_us, output ready);
endinterface

FILE: sv/msync_result_if.sv
// ---------------------------------------------------------------------------
// msync_result_if
// Result channel: symbol and lock status per item.
// ---------------------------------------------------------------------------
interface msync_result_if;
	logic                           valid;
	logic                           ready;
	logic                           symbol_valid;
	logic                           symbol_level;
	logic [msync_pkg::PERIOD_W-1:0] sample_period_us;
	logic                           locked;
	logic                           sync_error;
	logic [2:0]                     phase_code;

	modport source (output valid, output symbol_valid, output symbol_level,
		output sample_period_us, output locked, output sync_error,
		output phase_code, input ready);
	modport sink (input valid, input symbol_valid, input symbol_level,
		input sample_period_us, input locked, input sync_error,
		input phase_code, output ready);
endinterface

FILE: sv/msync_cfg_if.sv
// ---------------------------------------------------------------------------
// msync_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface msync_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [msync_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [msync_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: sv/manchester_sync_sampler.sv
// ---------------------------------------------------------------------------
// manchester_sync_sampler
// Manchester line sampler with preamble-based clock recovery.
// ---------------------------------------------------------------------------
// The block takes one line sample per item and returns exactly one result item
// for each, in order. It accepts an item in every cycle unless a result waits;
// the result of an item appears on the result channel in the cycle after it was
// accepted and is held in an output register, so a new sample is still taken
// while that result waits as long as the result is taken in the same cycle.
// The state update for an item is one pass through the sync state machine, the
// preamble duration compare and the quarter-sum adder, all between the sample
// handshake and the output register. Configuration writes are always ready and
// take effect in the next cycle; write them only while no item is in flight.
module manchester_sync_sampler #(
	parameter int TIME_WIDTH = msync_pkg::TIME_WIDTH_DEFAULT
) (
	input logic            clk,
	input logic            arst_n,
	msync_sample_if.sink   sample,
	msync_result_if.source result,
	msync_cfg_if.sink      cfg
);

	logic                              accept;
	logic                              out_valid_q;
	msync_pkg::msync_result_t          res_d;
	msync_pkg::msync_result_t          res_q;
	msync_pkg::msync_cfg_t             core_cfg;
	logic [msync_pkg::TOL_W-1:0]       match_tol_q;
	logic                              cfg_write;

	// The output register can take a new item whenever it is empty or being
	// drained in this same cycle.
	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	// Register file. The default period needs no storage of its own: it only
	// loads the recovered period at the moment it is written. Indexes that
	// name no register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_tol_q <= msync_pkg::MATCH_TOLERANCE_RST;
		end else if (cfg_write) begin
			case (cfg.reg_index)
				msync_pkg::CFG_MATCH_TOLERANCE: begin
					match_tol_q <= cfg.wdata[msync_pkg::TOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The core sees the new default period with a load strobe so the recovered
	// period follows it at once unless the line is locked or a sample is taken.
	assign core_cfg.match_tolerance = match_tol_q;
	assign core_cfg.default_period  = cfg.wdata[msync_pkg::PERIOD_W-1:0];
	assign core_cfg.period_load     = cfg_write &&
	                                  (cfg.reg_index == msync_pkg::CFG_DEFAULT_PERIOD);

	msync_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.line_level (sample.line_level),
		.time_us    (sample.time_us),
		.cfg        (core_cfg),
		.res_d      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.symbol_valid     = res_q.symbol_valid;
	assign result.symbol_level     = res_q.symbol_level;
	assign result.sample_period_us = res_q.sample_period_us;
	assign result.locked           = res_q.locked;
	assign result.sync_error       = res_q.sync_error;
	assign result.phase_code       = res_q.phase_code;

endmodule

FILE: sv/msync_core.sv
// ---------------------------------------------------------------------------
// msync_core
// Sync state machine, run counters and preamble period recovery.
// ---------------------------------------------------------------------------
module msync_core #(
	parameter int TIME_WIDTH = msync_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          line_level,
	input  logic [msync_pkg::TIME_W-1:0]  time_us,
	input  msync_pkg::msync_cfg_t         cfg,
	output msync_pkg::msync_result_t      res_d
);

	localparam int QW = TIME_WIDTH - 1;

	msync_pkg::phase_t                 phase_q, phase_d;
	logic [1:0]                        high_run_q, high_run_d;
	logic [1:0]                        low_run_q, low_run_d;
	logic [TIME_WIDTH-1:0]             mark_q, mark_d;
	logic [TIME_WIDTH-1:0]             high_dur_q, high_dur_d;
	logic [msync_pkg::PERIOD_W-1:0]    period_q, period_d;

	logic [TIME_WIDTH-1:0]             now;
	logic [TIME_WIDTH-1:0]             elapsed;
	logic [TIME_WIDTH-1:0]             half_diff;
	logic [TIME_WIDTH:0]               half_sum;
	logic [QW-1:0]                     quarter;
	logic [msync_pkg::PERIOD_W-1:0]    quarter_sat;
	logic                              halves_match;
	logic                              symbol;

	assign now     = TIME_WIDTH'(time_us);
	assign elapsed = now - mark_q;

	// Preamble check: the high half is stored, the low half is the elapsed time.
	assign half_diff    = (high_dur_q > elapsed) ? (high_dur_q - elapsed)
	                                             : (elapsed - high_dur_q);
	assign halves_match = half_diff < TIME_WIDTH'(cfg.match_tolerance);
	assign half_sum     = {1'b0, high_dur_q} + {1'b0, elapsed};
	assign quarter      = half_sum[TIME_WIDTH:2];
	assign quarter_sat  = (quarter > QW'(msync_pkg::PERIOD_MAX)) ? msync_pkg::PERIOD_MAX
	                                                             : msync_pkg::PERIOD_W'(quarter);

	always_comb begin
		phase_d    = phase_q;
		high_run_d = high_run_q;
		low_run_d  = low_run_q;
		mark_d     = mark_q;
		high_dur_d = high_dur_q;
		period_d   = period_q;
		case (phase_q)
			msync_pkg::PH_HIGH: begin
				if (line_level) begin
					high_run_d = high_run_q + 2'd1;
				end else if (high_run_q != 2'd0) begin
					phase_d = msync_pkg::PH_ERR;
				end else begin
					phase_d   = msync_pkg::PH_LOW;
					low_run_d = msync_pkg::RUN_FIRST;
				end
			end
			msync_pkg::PH_LOW: begin
				if (!line_level) begin
					low_run_d = low_run_q + 2'd1;
				end else if (low_run_q != 2'd0) begin
					phase_d = msync_pkg::PH_ERR;
				end else begin
					phase_d    = msync_pkg::PH_HIGH;
					high_run_d = msync_pkg::RUN_FIRST;
				end
			end
			msync_pkg::PH_SHIGH: begin
				if (!line_level) begin
					high_dur_d = elapsed;
					mark_d     = now;
					phase_d    = msync_pkg::PH_SLOW;
				end
			end
			msync_pkg::PH_SLOW: begin
				if (line_level) begin
					if (halves_match) begin
						phase_d    = msync_pkg::PH_HIGH;
						period_d   = quarter_sat;
						high_run_d = msync_pkg::RUN_FIRST;
					end else begin
						phase_d = msync_pkg::PH_ERR;
					end
				end
			end
			msync_pkg::PH_ERR: begin
				if (!line_level) begin
					phase_d = msync_pkg::PH_WAIT;
				end
			end
			default: begin
				if (line_level) begin
					phase_d = msync_pkg::PH_SHIGH;
					mark_d  = now;
				end
			end
		endcase

		symbol = (high_run_d == msync_pkg::RUN_SYMBOL) || (low_run_d == msync_pkg::RUN_SYMBOL);
		if (symbol) begin
			high_run_d = 2'd0;
			low_run_d  = 2'd0;
		end
	end

	always_comb begin
		res_d.symbol_valid     = symbol;
		res_d.symbol_level     = symbol & line_level;
		res_d.sample_period_us = period_d;
		res_d.locked           = (phase_d == msync_pkg::PH_HIGH) || (phase_d == msync_pkg::PH_LOW);
		res_d.sync_error       = (phase_d == msync_pkg::PH_ERR);
		case (phase_d)
			msync_pkg::PH_HIGH:  res_d.phase_code = msync_pkg::PHASE_CODE_HIGH;
			msync_pkg::PH_LOW:   res_d.phase_code = msync_pkg::PHASE_CODE_LOW;
			msync_pkg::PH_SHIGH: res_d.phase_code = msync_pkg::PHASE_CODE_SHIGH;
			msync_pkg::PH_SLOW:  res_d.phase_code = msync_pkg::PHASE_CODE_SLOW;
			msync_pkg::PH_ERR:   res_d.phase_code = msync_pkg::PHASE_CODE_ERR;
			default:             res_d.phase_code = msync_pkg::PHASE_CODE_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= msync_pkg::PH_WAIT;
			high_run_q <= 2'd0;
			low_run_q  <= 2'd0;
			mark_q     <= '0;
			high_dur_q <= '0;
			period_q   <= msync_pkg::DEFAULT_PERIOD_RST;
		end else if (step) begin
			phase_q    <= phase_d;
			high_run_q <= high_run_d;
			low_run_q  <= low_run_d;
			mark_q     <= mark_d;
			high_dur_q <= high_dur_d;
			period_q   <= period_d;
		end else if (cfg.period_load && (phase_q != msync_pkg::PH_HIGH)
				&& (phase_q != msync_pkg::PH_LOW)) begin
			// A new default period shows at once unless the line is locked or a sample is taken.
			period_q <= cfg.default_period;
		end
	end

endmodule
